### sv/zbr_pkg.sv
// ----------------------------------------------------------------------------
// zbr_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package zbr_pkg;

  localparam int MW   = 2;   // mode
  localparam int CW   = 11;  // screen coordinate
  localparam int ZW   = 16;  // depth
  localparam int SW   = 24;  // color
  localparam int EW   = 13;  // edge difference
  localparam int WW   = 27;  // edge weight
  localparam int WDW  = 14;  // edge weight increment
  localparam int NW   = 48;  // depth numerator
  localparam int DVW  = 25;  // divisor and remainder
  localparam int MAW  = 17;  // multiplier operand a
  localparam int MBW  = 28;  // multiplier operand b
  localparam int PW   = MAW + MBW;
  localparam int CNTW = 17;  // written pixel count
  localparam int STW  = 5;   // multiply step code

  localparam logic [MW-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MW-1:0] MODE_READ  = 2'd1;
  localparam logic [MW-1:0] MODE_CLEAR = 2'd2;

  localparam logic [STW-1:0] MS_UZ0   = 5'd0;
  localparam logic [STW-1:0] MS_UZ1   = 5'd1;
  localparam logic [STW-1:0] MS_UX0   = 5'd2;
  localparam logic [STW-1:0] MS_UX1   = 5'd3;
  localparam logic [STW-1:0] MS_UY0   = 5'd4;
  localparam logic [STW-1:0] MS_UY1   = 5'd5;
  localparam logic [STW-1:0] MS_BASE  = 5'd6;
  localparam logic [STW-1:0] MS_N0A   = 5'd7;
  localparam logic [STW-1:0] MS_N0B   = 5'd8;
  localparam logic [STW-1:0] MS_N0C   = 5'd9;
  localparam logic [STW-1:0] MS_NYA   = 5'd10;
  localparam logic [STW-1:0] MS_NYB   = 5'd11;
  localparam logic [STW-1:0] MS_NYC   = 5'd12;
  localparam logic [STW-1:0] MS_NXA   = 5'd13;
  localparam logic [STW-1:0] MS_NXB   = 5'd14;
  localparam logic [STW-1:0] MS_NXC   = 5'd15;
  localparam logic [STW-1:0] MS_RADDR = 5'd16;

  localparam logic [1:0] DS_N0 = 2'd0;
  localparam logic [1:0] DS_NY = 2'd1;
  localparam logic [1:0] DS_NX = 2'd2;

  localparam logic signed [ZW-1:0] DEPTH_MIN = 16'sh8000;

  typedef struct packed {
    logic           load;
    logic           mul_go;
    logic [STW-1:0] mul_step;
    logic           setup_fin;
    logic           div_start;
    logic [1:0]     div_sel;
    logic           walk_init;
    logic           walk_go;
    logic           clr_step;
    logic           rd_go;
    logic           out_load;
  } zbr_cmd_t;

  typedef struct packed {
    logic          degenerate;
    logic          div_done;
    logic          walk_last;
    logic          clr_last;
    logic [MW-1:0] mode;
  } zbr_stat_t;

endpackage

### sv/zbr_ram.sv
// ----------------------------------------------------------------------------
// zbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/zbr_divider.sv
// ----------------------------------------------------------------------------
// zbr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zbr_divider import zbr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic [NW-1:0]  quotient,
  output logic [DVW-1:0] remainder,
  output logic           done
);

  localparam int CTW = $clog2(NW + 1);

  logic           busy;
  logic [CTW-1:0] cnt;
  logic [DVW:0]   rem_sh;
  logic           fits;

  assign rem_sh = {remainder, quotient[NW-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[NW-2:0], fits};
      remainder <= fits ? DVW'(rem_sh - {1'b0, divisor}) : DVW'(rem_sh);
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

### sv/zbr_datapath.sv
// ----------------------------------------------------------------------------
// zbr_datapath
// Setup multiplier, depth divider, incremental box walk and frame stores.
// ----------------------------------------------------------------------------
module zbr_datapath import zbr_pkg::*; #(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  zbr_cmd_t              cmd,
  output zbr_stat_t             stat,
  input  logic [MW-1:0]         mode,
  input  logic signed [CW-1:0]  ax,
  input  logic signed [CW-1:0]  ay,
  input  logic signed [ZW-1:0]  az,
  input  logic signed [CW-1:0]  bx,
  input  logic signed [CW-1:0]  by_coord,
  input  logic signed [ZW-1:0]  bz,
  input  logic signed [CW-1:0]  cx,
  input  logic signed [CW-1:0]  cy,
  input  logic signed [ZW-1:0]  cz,
  input  logic [SW-1:0]         shade,
  output logic [CNTW-1:0]       pixels_written,
  output logic [SW-1:0]         read_color,
  output logic signed [ZW-1:0]  read_depth,
  output logic                  read_outside
);

  localparam int PIX = FB_WIDTH * FB_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int XW  = $clog2(FB_WIDTH);
  localparam int YW  = $clog2(FB_HEIGHT);
  localparam logic signed [CW:0] XMAX = (CW+1)'(FB_WIDTH - 1);
  localparam logic signed [CW:0] YMAX = (CW+1)'(FB_HEIGHT - 1);

  // transaction registers
  logic [MW-1:0]        mode_r;
  logic signed [CW-1:0] xa, ya, xb, yb, xc, yc;
  logic signed [ZW-1:0] za, zb, zc;
  logic [SW-1:0]        col_r;

  // bounding box
  logic signed [CW-1:0] mnx_ab, mxx_ab, mny_ab, mxy_ab;
  logic signed [CW-1:0] minx, maxx, miny, maxy;
  logic [XW-1:0]        x0, x1;
  logic [YW-1:0]        y0, y1;
  logic                 box_empty, outside;

  // edges
  logic signed [EW-1:0] e1x, e1y, e2x, e2y, pdx, pdy;

  // setup
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic [STW-1:0]        mul_tag;
  logic                  mul_vld;
  logic signed [WW-1:0]  p_w;
  logic signed [NW-1:0]  p_n;
  logic signed [WW-1:0]  uz, ux, uy, wsum;
  logic signed [WW-1:0]  wa0, wb0, wc0;
  logic signed [WDW-1:0] dway, dwby, dwcy, dwax, dwbx, dwcx;
  logic signed [WDW-1:0] sdwby, sdwcy, sdwbx, sdwcx;
  logic signed [NW-1:0]  n0, ny, nx;
  logic [AW-1:0]         base;
  logic [DVW-1:0]        d;

  // division
  logic signed [NW-1:0] nsel;
  logic [NW-1:0]        nabs;
  logic [NW-1:0]        div_q;
  logic [DVW-1:0]       div_r;
  logic                 div_done;
  logic signed [NW-1:0] qf;
  logic [DVW-1:0]       rf;
  logic signed [NW-1:0] q0, qy, qx;
  logic [DVW-1:0]       r0, ry, rx;

  // walk
  logic signed [NW-1:0] pq, cq, nq_y, nq_x;
  logic [DVW-1:0]       pr, cr, nr_y, nr_x;
  logic [DVW:0]         rsum_y, rsum_x;
  logic                 wrap_y, wrap_x;
  logic signed [WW-1:0] pwa, pwb, pwc, cwa, cwb, cwc;
  logic [AW-1:0]        paddr, caddr;
  logic [XW-1:0]        px;
  logic [YW-1:0]        py;
  logic                 in_tri;
  logic signed [ZW-1:0] zpix;

  logic                 s1_valid, s1_inside;
  logic signed [ZW-1:0] s1_z;
  logic [AW-1:0]        s1_addr;

  // stores
  logic [AW-1:0]        clr_addr;
  logic                 hit;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [ZW-1:0]        dep_wdata, dep_rdata;
  logic [SW-1:0]        col_wdata, col_rdata;
  logic [CNTW-1:0]      count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      xa <= ax;  ya <= ay;        za <= az;
      xb <= bx;  yb <= by_coord;  zb <= bz;
      xc <= cx;  yc <= cy;        zc <= cz;
      col_r <= shade;
    end
  end

  always_comb begin
    mnx_ab = (xa < xb) ? xa : xb;
    mxx_ab = (xa > xb) ? xa : xb;
    mny_ab = (ya < yb) ? ya : yb;
    mxy_ab = (ya > yb) ? ya : yb;
    minx   = (mnx_ab < xc) ? mnx_ab : xc;
    maxx   = (mxx_ab > xc) ? mxx_ab : xc;
    miny   = (mny_ab < yc) ? mny_ab : yc;
    maxy   = (mxy_ab > yc) ? mxy_ab : yc;
    x0 = minx[CW-1] ? '0 : XW'(minx);
    y0 = miny[CW-1] ? '0 : YW'(miny);
    x1 = ((CW+1)'(maxx) > XMAX) ? XW'(XMAX) : XW'(maxx);
    y1 = ((CW+1)'(maxy) > YMAX) ? YW'(YMAX) : YW'(maxy);
    box_empty = maxx[CW-1] || maxy[CW-1] || ((CW+1)'(minx) > XMAX) ||
                ((CW+1)'(miny) > YMAX);
    outside = xa[CW-1] || ya[CW-1] || ((CW+1)'(xa) > XMAX) ||
              ((CW+1)'(ya) > YMAX);
  end

  assign e1x = EW'(xb) - EW'(xa);
  assign e1y = EW'(yb) - EW'(ya);
  assign e2x = EW'(xc) - EW'(xa);
  assign e2y = EW'(yc) - EW'(ya);
  assign pdx = EW'(xa) - signed'(EW'(x0));
  assign pdy = EW'(ya) - signed'(EW'(y0));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_step)
      MS_UZ0:   begin mul_a = MAW'(e2x); mul_b = MBW'(e1y); end
      MS_UZ1:   begin mul_a = MAW'(e1x); mul_b = MBW'(e2y); end
      MS_UX0:   begin mul_a = MAW'(e1x); mul_b = MBW'(pdy); end
      MS_UX1:   begin mul_a = MAW'(pdx); mul_b = MBW'(e1y); end
      MS_UY0:   begin mul_a = MAW'(pdx); mul_b = MBW'(e2y); end
      MS_UY1:   begin mul_a = MAW'(e2x); mul_b = MBW'(pdy); end
      MS_BASE:  begin mul_a = MAW'(y0);  mul_b = MBW'(FB_WIDTH); end
      MS_RADDR: begin mul_a = MAW'(ya);  mul_b = MBW'(FB_WIDTH); end
      MS_N0A:   begin mul_a = MAW'(za);  mul_b = MBW'(wa0); end
      MS_N0B:   begin mul_a = MAW'(zb);  mul_b = MBW'(wb0); end
      MS_N0C:   begin mul_a = MAW'(zc);  mul_b = MBW'(wc0); end
      MS_NYA:   begin mul_a = MAW'(za);  mul_b = MBW'(dway); end
      MS_NYB:   begin mul_a = MAW'(zb);  mul_b = MBW'(dwby); end
      MS_NYC:   begin mul_a = MAW'(zc);  mul_b = MBW'(dwcy); end
      MS_NXA:   begin mul_a = MAW'(za);  mul_b = MBW'(dwax); end
      MS_NXB:   begin mul_a = MAW'(zb);  mul_b = MBW'(dwbx); end
      MS_NXC:   begin mul_a = MAW'(zc);  mul_b = MBW'(dwcx); end
      default:  begin mul_a = '0;        mul_b = '0; end
    endcase
  end

  assign p_w = mul_p[WW-1:0];
  assign p_n = NW'(mul_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
    end else begin
      mul_vld <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    mul_p   <= PW'(mul_a) * PW'(mul_b);
    mul_tag <= cmd.mul_step;
    if (mul_vld) begin
      unique case (mul_tag)
        MS_UZ0:   uz <= p_w;
        MS_UZ1:   uz <= uz - p_w;
        MS_UX0:   ux <= p_w;
        MS_UX1:   ux <= ux - p_w;
        MS_UY0:   uy <= p_w;
        MS_UY1:   uy <= uy - p_w;
        MS_BASE:  base <= mul_p[AW-1:0] + AW'(x0);
        MS_RADDR: base <= mul_p[AW-1:0] + AW'(xa);
        MS_N0A:   n0 <= p_n;
        MS_N0B:   n0 <= n0 + p_n;
        MS_N0C:   n0 <= n0 + p_n;
        MS_NYA:   ny <= p_n;
        MS_NYB:   ny <= ny + p_n;
        MS_NYC:   ny <= ny + p_n;
        MS_NXA:   nx <= p_n;
        MS_NXB:   nx <= nx + p_n;
        MS_NXC:   nx <= nx + p_n;
        default:  ;
      endcase
    end
  end

  // orient all weights by the sign of the signed area
  assign wsum  = uz - ux - uy;
  assign sdwcy = -WDW'(e1x);
  assign sdwby = WDW'(e2x);
  assign sdwcx = WDW'(e1y);
  assign sdwbx = -WDW'(e2y);

  always_ff @(posedge clk) begin
    if (cmd.setup_fin) begin
      d    <= DVW'(uz[WW-1] ? -uz : uz);
      wa0  <= uz[WW-1] ? -wsum : wsum;
      wb0  <= uz[WW-1] ? -uy : uy;
      wc0  <= uz[WW-1] ? -ux : ux;
      dwby <= uz[WW-1] ? -sdwby : sdwby;
      dwcy <= uz[WW-1] ? -sdwcy : sdwcy;
      dway <= uz[WW-1] ? (sdwby + sdwcy) : -(sdwby + sdwcy);
      dwbx <= uz[WW-1] ? -sdwbx : sdwbx;
      dwcx <= uz[WW-1] ? -sdwcx : sdwcx;
      dwax <= uz[WW-1] ? (sdwbx + sdwcx) : -(sdwbx + sdwcx);
    end
  end

  // floor division of the numerators by the area
  always_comb begin
    unique case (cmd.div_sel)
      DS_N0:   nsel = n0;
      DS_NY:   nsel = ny;
      default: nsel = nx;
    endcase
    nabs = nsel[NW-1] ? NW'(-nsel) : NW'(nsel);
    if (!nsel[NW-1]) begin
      qf = div_q;
      rf = div_r;
    end else if (div_r == '0) begin
      qf = -signed'(div_q);
      rf = '0;
    end else begin
      qf = ~signed'(div_q);
      rf = d - div_r;
    end
  end

  zbr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (nabs),
    .divisor   (d),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.div_sel)
        DS_N0:   begin q0 <= qf; r0 <= rf; end
        DS_NY:   begin qy <= qf; ry <= rf; end
        default: begin qx <= qf; rx <= rf; end
      endcase
    end
  end

  // incremental walk, column-major
  assign rsum_y = {1'b0, pr} + {1'b0, ry};
  assign wrap_y = rsum_y >= {1'b0, d};
  assign nr_y   = wrap_y ? DVW'(rsum_y - {1'b0, d}) : DVW'(rsum_y);
  assign nq_y   = pq + qy + NW'(wrap_y);
  assign rsum_x = {1'b0, cr} + {1'b0, rx};
  assign wrap_x = rsum_x >= {1'b0, d};
  assign nr_x   = wrap_x ? DVW'(rsum_x - {1'b0, d}) : DVW'(rsum_x);
  assign nq_x   = cq + qx + NW'(wrap_x);

  assign in_tri = !pwa[WW-1] && !pwb[WW-1] && !pwc[WW-1];
  assign zpix   = pq[ZW-1:0] + ZW'(pq[NW-1] && (pr != '0));

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      pq <= q0;  pr <= r0;  cq <= q0;  cr <= r0;
      pwa <= wa0; pwb <= wb0; pwc <= wc0;
      cwa <= wa0; cwb <= wb0; cwc <= wc0;
      paddr <= base; caddr <= base;
      px <= x0; py <= y0;
    end else if (cmd.walk_go) begin
      if (py != y1) begin
        pq <= nq_y; pr <= nr_y;
        pwa <= pwa + WW'(dway);
        pwb <= pwb + WW'(dwby);
        pwc <= pwc + WW'(dwcy);
        paddr <= paddr + AW'(FB_WIDTH);
        py <= py + 1'b1;
      end else begin
        pq <= nq_x; pr <= nr_x; cq <= nq_x; cr <= nr_x;
        pwa <= cwa + WW'(dwax); cwa <= cwa + WW'(dwax);
        pwb <= cwb + WW'(dwbx); cwb <= cwb + WW'(dwbx);
        pwc <= cwc + WW'(dwcx); cwc <= cwc + WW'(dwcx);
        paddr <= caddr + 1'b1; caddr <= caddr + 1'b1;
        py <= y0;
        px <= px + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      clr_addr <= '0;
    end else begin
      s1_valid <= cmd.walk_go;
      if (cmd.clr_step) begin
        clr_addr <= stat.clr_last ? '0 : clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_inside <= in_tri;
    s1_z      <= zpix;
    s1_addr   <= paddr;
    if (cmd.load) begin
      count <= '0;
    end else if (hit) begin
      count <= count + 1'b1;
    end
  end

  assign hit       = s1_valid && s1_inside && (signed'(dep_rdata) < s1_z);
  assign mem_we    = cmd.clr_step || hit;
  assign mem_waddr = cmd.clr_step ? clr_addr : s1_addr;
  assign dep_wdata = cmd.clr_step ? DEPTH_MIN : s1_z;
  assign col_wdata = cmd.clr_step ? '0 : col_r;
  assign mem_re    = cmd.walk_go || cmd.rd_go;
  assign mem_raddr = cmd.walk_go ? paddr : base;

  zbr_ram #(.WIDTH(ZW), .DEPTH(PIX)) u_depth (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (dep_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (dep_rdata)
  );

  zbr_ram #(.WIDTH(SW), .DEPTH(PIX)) u_color (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (col_wdata),
    .re    (cmd.rd_go),
    .raddr (base),
    .rdata (col_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixels_written <= (mode_r == MODE_DRAW) ? count : '0;
      read_outside   <= (mode_r == MODE_READ) && outside;
      if ((mode_r == MODE_READ) && !outside) begin
        read_color <= col_rdata;
        read_depth <= dep_rdata;
      end else begin
        read_color <= '0;
        read_depth <= '0;
      end
    end
  end

  assign stat.degenerate = (uz == '0) || box_empty;
  assign stat.div_done   = div_done;
  assign stat.walk_last  = (px == x1) && (py == y1);
  assign stat.clr_last   = clr_addr == AW'(PIX - 1);
  assign stat.mode       = mode_r;

  a_walk_nondegenerate: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_go |-> (d != '0))
    else $error("box walk with a zero-area triangle");

endmodule

### sv/zbr_ctrl.sv
// ----------------------------------------------------------------------------
// zbr_ctrl
// Sequencer for setup, division, box walk, pixel read and frame clear.
// ----------------------------------------------------------------------------
module zbr_ctrl import zbr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output zbr_cmd_t  cmd,
  input  zbr_stat_t stat
);

  typedef enum logic [4:0] {
    BOOT_CLR, IDLE, DECODE, CLR, GEO, SETUP, NMUL, NWAIT, DIV, DIVW,
    WINIT, WALK, DRAIN, RMUL, RACC, RREAD, RDATA, DONE
  } state_t;

  state_t         state;
  logic [STW-1:0] step;
  logic [1:0]     dsel;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.mul_step  = step;
    cmd.div_sel   = dsel;
    cmd.load      = (state == IDLE) && in_valid;
    cmd.mul_go    = (state == GEO) || (state == NMUL) || (state == RMUL);
    cmd.setup_fin = (state == SETUP);
    cmd.div_start = (state == DIV);
    cmd.walk_init = (state == WINIT);
    cmd.walk_go   = (state == WALK);
    cmd.clr_step  = (state == CLR) || (state == BOOT_CLR);
    cmd.rd_go     = (state == RREAD);
    cmd.out_load  = (state == DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BOOT_CLR;
      step      <= MS_UZ0;
      dsel      <= DS_N0;
      out_valid <= 1'b0;
    end else begin
      if ((state == DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BOOT_CLR: if (stat.clr_last) state <= IDLE;
        IDLE:     if (in_valid) state <= DECODE;
        DECODE: begin
          unique case (stat.mode)
            MODE_DRAW:  begin state <= GEO; step <= MS_UZ0; end
            MODE_READ:  begin state <= RMUL; step <= MS_RADDR; end
            MODE_CLEAR: state <= CLR;
            default:    state <= DONE;
          endcase
        end
        CLR:      if (stat.clr_last) state <= DONE;
        GEO: begin
          if (step == MS_BASE) begin
            state <= SETUP;
          end else begin
            step <= step + 1'b1;
          end
        end
        SETUP: begin
          if (stat.degenerate) begin
            state <= DONE;
          end else begin
            state <= NMUL;
            step  <= MS_N0A;
          end
        end
        NMUL: begin
          if (step == MS_NXC) begin
            state <= NWAIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        NWAIT: begin
          state <= DIV;
          dsel  <= DS_N0;
        end
        DIV:      state <= DIVW;
        DIVW: begin
          if (stat.div_done) begin
            if (dsel == DS_NX) begin
              state <= WINIT;
            end else begin
              dsel  <= dsel + 1'b1;
              state <= DIV;
            end
          end
        end
        WINIT:    state <= WALK;
        WALK:     if (stat.walk_last) state <= DRAIN;
        DRAIN:    state <= DONE;
        RMUL:     state <= RACC;
        RACC:     state <= RREAD;
        RREAD:    state <= RDATA;
        RDATA:    state <= DONE;
        DONE: begin
          if (!out_valid || out_ready) begin
            state <= IDLE;
          end
        end
        default:  state <= IDLE;
      endcase
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == DONE))
    else $error("result raised outside the completion state");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == WALK) && stat.walk_last |=> (state == DRAIN))
    else $error("walk did not stop at the last box pixel");

endmodule

### sv/zbuffer_triangle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// zbuffer_triangle_rasterizer_unit
// Triangle rasterizer with depth test over a frame of depth and color stores.
// ----------------------------------------------------------------------------
// Draw: setup on the shared 17x28 multiplier and three divisions, then a walk of the
//   clamped bounding box at one pixel per cycle; skipped for zero area or an empty box.
// Read: the pixel at (ax, ay). Clear: all FB_WIDTH*FB_HEIGHT entries, one entry a cycle.
// One transaction at a time; a waiting result does not block acceptance.
// Reset: a clearing pass over all FB_WIDTH*FB_HEIGHT entries with in_ready low.
module zbuffer_triangle_rasterizer_unit import zbr_pkg::*; #(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MW-1:0]        mode,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [ZW-1:0] az,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by_coord,
  input  logic signed [ZW-1:0] bz,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [ZW-1:0] cz,
  input  logic [SW-1:0]        shade,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CNTW-1:0]      pixels_written,
  output logic [SW-1:0]        read_color,
  output logic signed [ZW-1:0] read_depth,
  output logic                 read_outside
);

  zbr_cmd_t  cmd;
  zbr_stat_t stat;

  zbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  zbr_datapath #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .ax             (ax),
    .ay             (ay),
    .az             (az),
    .bx             (bx),
    .by_coord       (by_coord),
    .bz             (bz),
    .cx             (cx),
    .cy             (cy),
    .cz             (cz),
    .shade          (shade),
    .pixels_written (pixels_written),
    .read_color     (read_color),
    .read_depth     (read_depth),
    .read_outside   (read_outside)
  );

endmodule
